@@ rtl/core/sfr_pkg.sv @@
// Types and constants shared by the status frame receiver.
// Command codes, frame lengths, result status codes and the frame descriptor.
// No dependencies.
package sfr_pkg;

    // Command byte values of the four frame kinds.
    localparam logic [7:0] MSG_STATUS  = 8'h01;
    localparam logic [7:0] MSG_BATTERY = 8'h05;
    localparam logic [7:0] MSG_MOTOR   = 8'h0A;
    localparam logic [7:0] MSG_SENSOR  = 8'h0F;

    // Exact frame lengths in bytes, counted as six-bit lengths.
    localparam logic [5:0] LEN_STATUS  = 6'd4;
    localparam logic [5:0] LEN_BATTERY = 6'd7;
    localparam logic [5:0] LEN_MOTOR   = 6'd11;
    localparam logic [5:0] LEN_SENSOR  = 6'd15;

    // Index of the final value of each good frame.
    localparam logic [2:0] LAST_STATUS  = 3'd0;
    localparam logic [2:0] LAST_BATTERY = 3'd1;
    localparam logic [2:0] LAST_MOTOR   = 3'd3;
    localparam logic [2:0] LAST_SENSOR  = 3'd5;

    // Byte address of the primary id register.
    localparam logic [1:0] ADDR_PRIMARY_ID = 2'd0;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_WRONG_ID = 3'd1,
        ST_BAD_CMD  = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_BAD_SUM  = 3'd4
    } status_t;

    // How the value of a result is formed.
    typedef enum logic [1:0] {
        VAL_ZERO = 2'd0,
        VAL_BYTE = 2'd1,
        VAL_WORD = 2'd2
    } val_sel_t;

    // One finished frame waiting to be delivered.
    typedef struct packed {
        logic       bank;
        status_t    status;
        logic [7:0] kind;
        logic [2:0] last_idx;
        val_sel_t   sel;
    } frame_desc_t;

endpackage

@@ rtl/core/status_frame_receiver.sv @@
// Status frame receiver: collects received bytes into frames, checks them
// and delivers decoded values or an error code as a run of result words.
// Depends on sfr_pkg.
//
// Usage
//   Input channel (in_valid, in_stall, rx_byte, end_of_chunk) takes one word
//   per cycle while in_stall is low. A frame ends on a word with end_of_chunk
//   set or when MAX_FRAME words have arrived. Output channel (out_valid,
//   out_stall, status, msg_kind, value_index, value, last) gives one result
//   word per cycle while out_stall is low: one word for an error, one to six
//   values for a good frame, last set on the final word. A frame is queued as
//   its final byte is accepted; the output register takes its first result
//   once free. Throughput is one input word per cycle while in_stall is low.
//   The frame bytes live in two banks of synchronous memory (even and odd byte
//   lanes), so a frame is received into one bank while the previous one is
//   read out of the other. If a second finished frame waits behind one still
//   being delivered, in_stall rises until the first has been read out; a
//   stalled output therefore eventually stalls the input.
//   Reset clears the byte count, the running XOR, the frame queue and the
//   output valid; the byte memories are not cleared and need no clearing pass.
//   The user writes primary_id (byte address 0) over the APB-style port while idle; the block does not enforce it.
module status_frame_receiver #(
    parameter int MAX_FRAME = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   rx_byte,
    input  logic         end_of_chunk,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [2:0]   status,
    output logic [7:0]   msg_kind,
    output logic [2:0]   value_index,
    output logic signed [15:0] value,
    output logic         last
);

    import sfr_pkg::*;

    // Configuration
    logic [7:0] primary_id_reg;

    // Receive side
    logic [4:0] byte_count_reg, byte_count_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic       wr_bank_reg, wr_bank_next;
    logic [7:0] byte0_reg;
    logic [7:0] byte1_reg;

    // Frame queue: one frame being delivered and one waiting
    frame_desc_t act_reg, act_next;
    logic        act_valid_reg, act_valid_next;
    logic [2:0]  act_idx_reg, act_idx_next;
    frame_desc_t pnd_reg, pnd_next;
    logic        pnd_valid_reg, pnd_valid_next;

    // Output register
    logic       out_valid_reg;
    status_t    out_status_reg;
    logic [7:0] out_kind_reg;
    logic [2:0] out_idx_reg;
    logic       out_last_reg;
    val_sel_t   out_sel_reg;
    logic [7:0] even_q_reg;
    logic [7:0] odd_q_reg;

    // Byte memories: even and odd byte positions, two banks of eight each
    logic [7:0] mem_even [0:15];
    logic [7:0] mem_odd  [0:15];

    logic        in_fire;
    logic        chunk_end;
    logic        frame_done;
    logic [5:0]  len_ext;
    logic [7:0]  xor_in;
    logic [7:0]  id_byte;
    logic [7:0]  kind_byte;
    logic        cmd_ok;
    logic [5:0]  need_len;
    logic [2:0]  need_last;
    frame_desc_t new_desc;
    logic        load;
    logic        act_free;
    logic [3:0]  wr_addr;
    logic [3:0]  rd_addr;
    logic        cfg_write;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_PRIMARY_ID);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_id_reg <= 8'h00;
        end
        else if (cfg_write)
        begin
            primary_id_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = 32'h0;
        if (paddr == ADDR_PRIMARY_ID)
        begin
            prdata = {24'h0, primary_id_reg};
        end
    end

    // ---------------------------------------------------------------
    // Frame check on the final byte
    // ---------------------------------------------------------------
    assign in_stall   = pnd_valid_reg;
    assign in_fire    = in_valid && !in_stall;
    assign len_ext    = {1'b0, byte_count_reg} + 6'd1;
    assign chunk_end  = end_of_chunk || (len_ext == 6'(MAX_FRAME));
    assign frame_done = in_fire && chunk_end;
    assign xor_in     = running_xor_reg ^ rx_byte;
    assign id_byte    = (byte_count_reg == 5'd0) ? rx_byte : byte0_reg;

    always_comb
    begin
        if (byte_count_reg == 5'd0)
        begin
            kind_byte = 8'h00;
        end
        else if (byte_count_reg == 5'd1)
        begin
            kind_byte = rx_byte;
        end
        else
        begin
            kind_byte = byte1_reg;
        end
    end

    always_comb
    begin
        cmd_ok    = 1'b1;
        need_len  = LEN_STATUS;
        need_last = LAST_STATUS;
        unique case (kind_byte)
            MSG_STATUS:
            begin
                need_len  = LEN_STATUS;
                need_last = LAST_STATUS;
            end
            MSG_BATTERY:
            begin
                need_len  = LEN_BATTERY;
                need_last = LAST_BATTERY;
            end
            MSG_MOTOR:
            begin
                need_len  = LEN_MOTOR;
                need_last = LAST_MOTOR;
            end
            MSG_SENSOR:
            begin
                need_len  = LEN_SENSOR;
                need_last = LAST_SENSOR;
            end
            default:
            begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        new_desc.bank     = wr_bank_reg;
        new_desc.kind     = kind_byte;
        new_desc.last_idx = 3'd0;
        new_desc.sel      = VAL_ZERO;
        new_desc.status   = ST_OK;
        priority if (id_byte != primary_id_reg)
        begin
            new_desc.status = ST_WRONG_ID;
        end
        else if (byte_count_reg == 5'd0)
        begin
            new_desc.status = ST_BAD_CMD;
        end
        else if (!cmd_ok)
        begin
            new_desc.status = ST_BAD_CMD;
        end
        else if (len_ext != need_len)
        begin
            new_desc.status = ST_BAD_LEN;
        end
        else if (xor_in != 8'h00)
        begin
            new_desc.status = ST_BAD_SUM;
        end
        else
        begin
            new_desc.last_idx = need_last;
            new_desc.sel      = (kind_byte == MSG_STATUS) ? VAL_BYTE : VAL_WORD;
        end
    end

    // ---------------------------------------------------------------
    // Receive counters and frame queue
    // ---------------------------------------------------------------
    assign load     = act_valid_reg && (!out_valid_reg || !out_stall);
    assign act_free = !act_valid_reg || (load && (act_idx_reg == act_reg.last_idx));

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        running_xor_next = running_xor_reg;
        wr_bank_next     = wr_bank_reg;
        if (in_fire)
        begin
            if (chunk_end)
            begin
                byte_count_next  = 5'd0;
                running_xor_next = 8'h00;
                wr_bank_next     = !wr_bank_reg;
            end
            else
            begin
                byte_count_next  = len_ext[4:0];
                running_xor_next = xor_in;
            end
        end
    end

    always_comb
    begin
        act_next       = act_reg;
        act_valid_next = act_valid_reg;
        act_idx_next   = act_idx_reg;
        pnd_next       = pnd_reg;
        pnd_valid_next = pnd_valid_reg;
        if (act_free)
        begin
            act_idx_next   = 3'd0;
            pnd_valid_next = 1'b0;
            if (pnd_valid_reg)
            begin
                act_next       = pnd_reg;
                act_valid_next = 1'b1;
            end
            else if (frame_done)
            begin
                act_next       = new_desc;
                act_valid_next = 1'b1;
            end
            else
            begin
                act_valid_next = 1'b0;
            end
        end
        else
        begin
            if (load)
            begin
                act_idx_next = act_idx_reg + 3'd1;
            end
            if (frame_done)
            begin
                pnd_next       = new_desc;
                pnd_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= 5'd0;
            running_xor_reg <= 8'h00;
            wr_bank_reg     <= 1'b0;
            act_valid_reg   <= 1'b0;
            act_idx_reg     <= 3'd0;
            pnd_valid_reg   <= 1'b0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            running_xor_reg <= running_xor_next;
            wr_bank_reg     <= wr_bank_next;
            act_valid_reg   <= act_valid_next;
            act_idx_reg     <= act_idx_next;
            pnd_valid_reg   <= pnd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        pnd_reg <= pnd_next;
        if (in_fire && (byte_count_reg == 5'd0))
        begin
            byte0_reg <= rx_byte;
        end
        if (in_fire && (byte_count_reg == 5'd1))
        begin
            byte1_reg <= rx_byte;
        end
    end

    // ---------------------------------------------------------------
    // Byte memories
    // ---------------------------------------------------------------
    // Value i of a frame is bytes 2+2i (even lane) and 3+2i (odd lane), which
    // both sit at lane address i+1 of the frame's bank.
    assign wr_addr = {wr_bank_reg, byte_count_reg[3:1]};
    assign rd_addr = {act_reg.bank, act_idx_reg + 3'd1};

    always_ff @(posedge clk)
    begin
        if (in_fire && !byte_count_reg[4])
        begin
            if (byte_count_reg[0])
            begin
                mem_odd[wr_addr] <= rx_byte;
            end
            else
            begin
                mem_even[wr_addr] <= rx_byte;
            end
        end
        if (load)
        begin
            even_q_reg <= mem_even[rd_addr];
            odd_q_reg  <= mem_odd[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg <= act_reg.status;
            out_kind_reg   <= act_reg.kind;
            out_idx_reg    <= act_idx_reg;
            out_last_reg   <= (act_idx_reg == act_reg.last_idx);
            out_sel_reg    <= act_reg.sel;
        end
    end

    always_comb
    begin
        case (out_sel_reg)
            VAL_BYTE: value = {8'h00, even_q_reg};
            VAL_WORD: value = {odd_q_reg, even_q_reg};
            default:  value = 16'sh0000;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign msg_kind    = out_kind_reg;
    assign value_index = out_idx_reg;
    assign last        = out_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A waiting frame only exists behind one being delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        pnd_valid_reg |-> act_valid_reg)
        else $error("waiting frame without a frame in delivery");

    // The bank being read out is never the bank being written.
    assert property (@(posedge clk) disable iff (!rst_n)
        (act_valid_reg && !pnd_valid_reg) |-> (act_reg.bank != wr_bank_reg))
        else $error("receive bank collides with delivery bank");

    assert property (@(posedge clk) disable iff (!rst_n)
        pnd_valid_reg |-> (pnd_reg.bank != act_reg.bank))
        else $error("queued frames share a bank");

    // The value counter never runs past the frame's final value.
    assert property (@(posedge clk) disable iff (!rst_n)
        act_valid_reg |-> (act_idx_reg <= act_reg.last_idx))
        else $error("value index beyond end of frame");

    // Every frame ends by MAX_FRAME bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, byte_count_reg} < 6'(MAX_FRAME)))
        else $error("byte count reached frame limit without ending");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the status frame receiver: random and directed
// byte streams, APB writes of the primary id, bursty sender and stalling receiver.
// Depends on sfr_pkg and status_frame_receiver.
`timescale 1ns / 100ps

module testbench;
    import sfr_pkg::*;

    localparam int FRAME_LIMIT  = 16;
    localparam int RANDOM_WORDS = 75;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 140;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 100000;

    typedef struct packed {
        logic [7:0] b;
        logic       eoc;
    } in_word_t;

    typedef struct {
        status_t    st;
        logic [7:0] kind;
        logic [2:0] idx;
        logic [15:0] val;
        logic       last;
    } result_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = '0;
    logic        end_of_chunk = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [7:0]  msg_kind;
    logic [2:0]  value_index;
    logic signed [15:0] value;
    logic        last;

    // Testbench copy of the receiver state and its register.
    logic [7:0]  cur_id = 8'h00;
    logic [7:0]  frame_store [16];
    logic [4:0]  fill_count = '0;
    logic [7:0]  chk_xor = '0;

    in_word_t     pending_words[$];
    result_word_t expected_results[$];

    int error_count    = 0;
    int cycle_count    = 0;
    int accepted_words = 0;
    int queued_words   = 0;
    int gap_left       = 0;
    int burst_left     = 1;
    int stall_mode     = 0;
    int mode_left      = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    status_frame_receiver #(
        .MAX_FRAME(FRAME_LIMIT)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .end_of_chunk(end_of_chunk),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .msg_kind(msg_kind),
        .value_index(value_index),
        .value(value),
        .last(last)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Exact length of each known command; zero marks an unknown command.
    function automatic logic [5:0] frame_len(input logic [7:0] kind);
        case (kind)
            MSG_STATUS:  return LEN_STATUS;
            MSG_BATTERY: return LEN_BATTERY;
            MSG_MOTOR:   return LEN_MOTOR;
            MSG_SENSOR:  return LEN_SENSOR;
            default:     return 6'd0;
        endcase
    endfunction

    // Updates the frame state with one accepted word and queues the results it causes.
    function automatic void predict_frame_word(input logic [7:0] b, input logic eoc);
        logic [5:0]   len;
        logic [7:0]   kind;
        logic [5:0]   need;
        logic [2:0]   top;
        result_word_t w;
        len = {1'b0, fill_count} + 6'd1;
        if (fill_count < 5'd16)
            frame_store[fill_count[3:0]] = b;
        chk_xor = chk_xor ^ b;
        if (!eoc && len < FRAME_LIMIT)
        begin
            fill_count = len[4:0];
            return;
        end
        kind = (len >= 6'd2) ? frame_store[1] : 8'h00;
        need = frame_len(kind);
        w.kind = kind;
        w.idx  = 3'd0;
        w.val  = 16'h0000;
        w.last = 1'b1;
        if (frame_store[0] != cur_id)
            w.st = ST_WRONG_ID;
        else if (len < 6'd2)
            w.st = ST_BAD_CMD;
        else if (need == 6'd0)
            w.st = ST_BAD_CMD;
        else if (len != need)
            w.st = ST_BAD_LEN;
        else if (chk_xor != 8'h00)
            w.st = ST_BAD_SUM;
        else
            w.st = ST_OK;
        if (w.st != ST_OK || kind == MSG_STATUS)
        begin
            if (w.st == ST_OK)
                w.val = {8'h00, frame_store[2]};
            expected_results.push_back(w);
        end
        else
        begin
            case (kind)
                MSG_BATTERY: top = LAST_BATTERY;
                MSG_MOTOR:   top = LAST_MOTOR;
                default:     top = LAST_SENSOR;
            endcase
            for (int i = 0; i <= int'(top); i++)
            begin
                w.idx  = 3'(i);
                w.val  = {frame_store[3 + 2 * i], frame_store[2 + 2 * i]};
                w.last = (i == int'(top));
                expected_results.push_back(w);
            end
        end
        fill_count = '0;
        chk_xor = '0;
    endfunction

    // Sender: bursts of words with random gaps; a stalled word is held as it is.
    always @(posedge clk)
    begin : driver
        logic     advance;
        in_word_t nxt;
        if (rst_n)
        begin
            advance = !in_valid || !in_stall;
            if (in_valid && !in_stall)
            begin
                predict_frame_word(rx_byte, end_of_chunk);
                accepted_words++;
            end
            if (advance)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    nxt = pending_words.pop_front();
                    in_valid <= 1'b1;
                    rx_byte <= nxt.b;
                    end_of_chunk <= nxt.eoc;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern that changes mode now and then, plus one long hold-off.
    always @(posedge clk)
    begin : receiver
        logic stall_now;
        if (rst_n)
        begin
            if (!hold_done && accepted_words >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(3);
                mode_left = $urandom_range(20, 120);
            end
            else
                mode_left--;
            case (stall_mode)
                0:       stall_now = 1'b0;
                1:       stall_now = ($urandom_range(3) == 0);
                2:       stall_now = ($urandom_range(3) != 0);
                default: stall_now = mode_left[2];
            endcase
            if (hold_left > 0)
            begin
                stall_now = 1'b1;
                hold_left--;
            end
            out_stall <= stall_now;
        end
    end

    always @(posedge clk)
    begin : monitor
        result_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result word status %0d kind %02h",
                                          status, msg_kind));
            else
            begin
                w = expected_results.pop_front();
                if (status !== w.st)
                    report_mismatch($sformatf("status %0d, expected %0d", status, w.st));
                if (msg_kind !== w.kind)
                    report_mismatch($sformatf("msg_kind %02h, expected %02h", msg_kind, w.kind));
                if (value_index !== w.idx)
                    report_mismatch($sformatf("value_index %0d, expected %0d",
                                              value_index, w.idx));
                if (value !== w.val)
                    report_mismatch($sformatf("value %04h, expected %04h", value, w.val));
                if (last !== w.last)
                    report_mismatch($sformatf("last %0b, expected %0b", last, w.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_word(input logic [7:0] b, input logic eoc);
        in_word_t w;
        w.b = b;
        w.eoc = eoc;
        pending_words.push_back(w);
        queued_words++;
    endtask

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_kind();
        case ($urandom_range(3))
            0:       return MSG_STATUS;
            1:       return MSG_BATTERY;
            2:       return MSG_MOTOR;
            default: return MSG_SENSOR;
        endcase
    endfunction

    // Queues a chunk of len words; at len >= 3 the final byte balances the XOR unless
    // the checksum is to be broken. A full-length chunk may end on the count.
    task automatic push_frame(input logic [7:0] id, input logic [7:0] cmd, input int len,
                              input bit sum_ok);
        logic [7:0] frame_buf [16];
        logic [7:0] acc;
        logic       eoc;
        acc = 8'h00;
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                frame_buf[i] = id;
            else if (i == 1)
                frame_buf[i] = cmd;
            else
                frame_buf[i] = payload_byte();
            if (i < len - 1)
                acc = acc ^ frame_buf[i];
        end
        if (len >= 3)
        begin
            frame_buf[len - 1] = acc;
            if (!sum_ok)
                frame_buf[len - 1] = acc ^ 8'(1 << $urandom_range(7));
        end
        for (int i = 0; i < len; i++)
        begin
            if (i != len - 1)
                eoc = 1'b0;
            else if (len == FRAME_LIMIT)
                eoc = 1'($urandom_range(1));
            else
                eoc = 1'b1;
            push_word(frame_buf[i], eoc);
        end
    endtask

    // Mostly well-formed frames with random content; the rest broken or noise.
    task automatic random_frame();
        int         r;
        int         len;
        int         need;
        logic [7:0] kind;
        r = $urandom_range(99);
        kind = pick_kind();
        need = int'(frame_len(kind));
        if (r < 60)
            push_frame(cur_id, kind, need, 1'b1);
        else if (r < 70)
        begin
            do
                len = $urandom_range(2, FRAME_LIMIT);
            while (len == need);
            push_frame(cur_id, kind, len, 1'b1);
        end
        else if (r < 80)
            push_frame(cur_id, kind, need, 1'b0);
        else if (r < 88)
            push_frame(cur_id ^ 8'($urandom_range(1, 255)), kind,
                       $urandom_range(1, FRAME_LIMIT), 1'b1);
        else if (r < 95)
        begin
            do
                kind = 8'($urandom_range(255));
            while (frame_len(kind) != 6'd0);
            push_frame(cur_id, kind, $urandom_range(2, FRAME_LIMIT), 1'b1);
        end
        else
        begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
                push_word(8'($urandom_range(255)), ($urandom_range(5) == 0));
        end
    endtask

    // Every phase closes its last chunk so that no partial frame spans a register write.
    task automatic random_phase();
        int start;
        start = queued_words;
        while (queued_words - start < RANDOM_WORDS)
            random_frame();
        push_word(payload_byte(), 1'b1);
    endtask

    task automatic directed_words();
        push_frame(cur_id, MSG_STATUS, int'(LEN_STATUS), 1'b1);
        // Battery frame carrying the most negative and the most positive value.
        push_word(cur_id, 1'b0);
        push_word(MSG_BATTERY, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h80, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h7F, 1'b0);
        push_word(cur_id ^ MSG_BATTERY, 1'b1);
        // A one-word chunk with a matching id is a bad command of kind zero.
        push_word(cur_id, 1'b1);
        push_word(cur_id ^ 8'hFF, 1'b1);
        push_frame(cur_id ^ 8'h01, MSG_SENSOR, 2, 1'b1);
        push_frame(cur_id, 8'h00, 3, 1'b1);
        push_frame(cur_id, MSG_STATUS, 3, 1'b1);
        push_frame(cur_id, MSG_STATUS, int'(LEN_STATUS), 1'b0);
    endtask

    task automatic apb_access(input logic wr, input logic [7:0] data,
                              output logic [31:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_PRIMARY_ID;
        pwdata <= {24'h000000, data};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_primary_id();
        logic [31:0] rdata;
        apb_access(1'b0, 8'h00, rdata);
        if (rdata[7:0] !== cur_id)
            report_mismatch($sformatf("primary_id reads %02h, expected %02h",
                                      rdata[7:0], cur_id));
    endtask

    task automatic set_primary_id(input logic [7:0] id);
        logic [31:0] rdata;
        apb_access(1'b1, id, rdata);
        cur_id = id;
        check_primary_id();
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_primary_id();

        directed_words();
        random_phase();
        wait_drained();

        set_primary_id(8'hFF);
        random_phase();
        wait_drained();

        set_primary_id(8'($urandom_range(1, 254)));
        random_phase();
        wait_drained();

        set_primary_id(8'h00);
        random_phase();
        wait_drained();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/sfr_pkg.sv
rtl/core/status_frame_receiver.sv
dv/testbench.sv
